// File: rtl/rtlr_pkg.sv
// shared types, constants and per-channel ramp functions for the rgb timed level ramp
// no dependencies; used by every module of the block
`default_nettype none

package rtlr_pkg;

  // field widths
  localparam int unsigned LVL_W     = 8;
  localparam int unsigned RT_W      = 15;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned DIV_CNT_W = $clog2(RT_W);

  // default number of built colour channels
  localparam int unsigned CHANNELS_DEF = 3;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_SET   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // input beat
  typedef struct packed {
    kind_e             kind;
    logic [1:0]        channel;
    logic [LVL_W-1:0]  target;
    logic [LVL_W-1:0]  step_size;
    logic [RT_W-1:0]   fade_ms;
  } in_t;

  // output beat
  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic             red_done;
    logic             green_done;
    logic             blue_done;
  } out_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_APPLY,
    S_PUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic apply;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_ok;
    logic div_done;
    logic out_free;
  } sts_t;

  // result of one channel evaluation
  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [TICK_W-1:0] ticks;
  } eval_t;

  // one step toward the target, clamped at the target and at zero
  function automatic logic [LVL_W-1:0] next_level(
    input logic [LVL_W-1:0] cur,
    input logic [LVL_W-1:0] from,
    input logic [LVL_W-1:0] to,
    input logic [LVL_W-1:0] inc
  );
    logic [LVL_W:0]   sum;
    logic [LVL_W-1:0] dif;
    logic [LVL_W-1:0] res;
    sum = {1'b0, cur} + {1'b0, inc};
    dif = cur - inc;
    if (to >= from) begin
      res = (sum <= {1'b0, to}) ? sum[LVL_W-1:0] : to;
    end else if ((inc >= cur) || (dif < to)) begin
      res = to;
    end else begin
      res = dif;
    end
    return res;
  endfunction

  // ramp evaluation of one channel
  function automatic eval_t eval_chan(
    input logic [LVL_W-1:0]  lvl,
    input logic [LVL_W-1:0]  from,
    input logic [LVL_W-1:0]  to,
    input logic [LVL_W-1:0]  inc,
    input logic [RT_W-1:0]   intv,
    input logic [TICK_W-1:0] ticks,
    input logic              inst
  );
    eval_t r;
    r.level = lvl;
    r.ticks = ticks;
    if (inst) begin
      r.level = to;
    end else if ((lvl != to) && (ticks >= {{(TICK_W-RT_W){1'b0}}, intv})) begin
      r.ticks = '0;
      r.level = next_level(lvl, from, to, inc);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rtlr_div.sv
// restoring divider, one quotient bit per cycle, for the ramp step interval
// depends on rtlr_pkg
`default_nettype none

module rtlr_div
  import rtlr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RT_W-1:0]  dividend_i,
  input  wire logic [LVL_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [RT_W-1:0]       quotient_o
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(RT_W - 1);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [LVL_W-1:0]     rem_q, rem_d;
  logic [LVL_W-1:0]     dsr_q, dsr_d;
  logic [RT_W-1:0]      quo_q, quo_d;
  logic [LVL_W:0]       shifted;
  logic                 fits;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[RT_W-1]};
    fits    = shifted >= {1'b0, dsr_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? LVL_W'(shifted - {1'b0, dsr_q}) : shifted[LVL_W-1:0];
      quo_d = {quo_q[RT_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/rtlr_dp.sv
// datapath: per-channel ramp state, item latch, interval divider and output register
// depends on rtlr_pkg and rtlr_div
`default_nettype none

module rtlr_dp
  import rtlr_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  // channel state
  logic [LVL_W-1:0]  level_q  [CHANNELS], level_d  [CHANNELS];
  logic [LVL_W-1:0]  start_q  [CHANNELS], start_d  [CHANNELS];
  logic [LVL_W-1:0]  tgt_q    [CHANNELS], tgt_d    [CHANNELS];
  logic [LVL_W-1:0]  step_q   [CHANNELS], step_d   [CHANNELS];
  logic [RT_W-1:0]   intv_q   [CHANNELS], intv_d   [CHANNELS];
  logic [TICK_W-1:0] ticks_q  [CHANNELS], ticks_d  [CHANNELS];
  logic              inst_q   [CHANNELS], inst_d   [CHANNELS];

  // latched item
  in_t              item_q;
  logic             ch_ok_q;
  logic [LVL_W-1:0] delta_q;

  logic             ch_ok;
  logic [LVL_W-1:0] cur_lvl;
  logic [LVL_W-1:0] delta;
  logic             div_busy;
  logic [RT_W-1:0]  quotient;

  logic             out_valid_q, out_valid_d;
  out_t             out_q;
  out_t             out_d;
  logic             out_free;

  // addressed channel and distance to the new target
  always_comb begin
    ch_ok   = int'(in_data_i.channel) < CHANNELS;
    cur_lvl = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(in_data_i.channel) == c) begin
        cur_lvl = level_q[c];
      end
    end
    delta = (in_data_i.target >= cur_lvl) ? (in_data_i.target - cur_lvl)
                                          : (cur_lvl - in_data_i.target);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= in_data_i;
      ch_ok_q <= ch_ok;
      delta_q <= delta;
    end
  end

  rtlr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (in_data_i.fade_ms),
    .divisor_i  (delta),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // apply the latched item: ticks and clears to every channel, starts and sets to the addressed one
  always_comb begin
    logic [TICK_W-1:0] inc;
    eval_t             ev;
    logic              sel;
    for (int c = 0; c < CHANNELS; c++) begin
      level_d[c] = level_q[c];
      start_d[c] = start_q[c];
      tgt_d[c]   = tgt_q[c];
      step_d[c]  = step_q[c];
      intv_d[c]  = intv_q[c];
      ticks_d[c] = ticks_q[c];
      inst_d[c]  = inst_q[c];
      ev         = '0;
      inc        = (ticks_q[c] == '1) ? ticks_q[c] : ticks_q[c] + TICK_W'(1);
      sel        = ch_ok_q && (int'(item_q.channel) == c);
      if (cmd_i.apply) begin
        unique case (item_q.kind)
          KIND_TICK: begin
            ev = eval_chan(level_q[c], start_q[c], tgt_q[c], step_q[c], intv_q[c],
                           inc, inst_q[c]);
            level_d[c] = ev.level;
            ticks_d[c] = ev.ticks;
          end
          KIND_START: begin
            if (sel) begin
              start_d[c] = level_q[c];
              tgt_d[c]   = item_q.target;
              step_d[c]  = item_q.step_size;
              intv_d[c]  = (delta_q == '0) ? '0 : quotient;
              inst_d[c]  = item_q.fade_ms == '0;
              ev = eval_chan(level_q[c], level_q[c], item_q.target, item_q.step_size,
                             intv_d[c], ticks_q[c], inst_d[c]);
              level_d[c] = ev.level;
              ticks_d[c] = ev.ticks;
            end
          end
          KIND_SET: begin
            if (sel) begin
              level_d[c] = item_q.target;
              start_d[c] = item_q.target;
              tgt_d[c]   = item_q.target;
              inst_d[c]  = 1'b0;
            end
          end
          KIND_CLEAR: begin
            level_d[c] = '0;
            start_d[c] = '0;
            tgt_d[c]   = '0;
            inst_d[c]  = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        level_q[c] <= '0;
        start_q[c] <= '0;
        tgt_q[c]   <= '0;
        step_q[c]  <= LVL_W'(1);
        intv_q[c]  <= '0;
        ticks_q[c] <= '0;
        inst_q[c]  <= 1'b0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        level_q[c] <= level_d[c];
        start_q[c] <= start_d[c];
        tgt_q[c]   <= tgt_d[c];
        step_q[c]  <= step_d[c];
        intv_q[c]  <= intv_d[c];
        ticks_q[c] <= ticks_d[c];
        inst_q[c]  <= inst_d[c];
      end
    end
  end

  // three-colour view, unbuilt channels read as level 0 and done
  logic [LVL_W-1:0] view_lvl  [3];
  logic             view_done [3];

  for (genvar j = 0; j < 3; j++) begin : g_view
    if (j < CHANNELS) begin : g_built
      assign view_lvl[j]  = level_q[j];
      assign view_done[j] = level_q[j] == tgt_q[j];
    end else begin : g_absent
      assign view_lvl[j]  = '0;
      assign view_done[j] = 1'b1;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d             = out_q;
    out_d.red_level   = view_lvl[0];
    out_d.green_level = view_lvl[1];
    out_d.blue_level  = view_lvl[2];
    out_d.red_done    = view_done[0];
    out_d.green_done  = view_done[1];
    out_d.blue_done   = view_done[2];
    out_valid_d = out_valid_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.start_ok = (in_data_i.kind == KIND_START) && ch_ok;
  assign sts_o.div_done = !div_busy;
  assign sts_o.out_free = out_free;

endmodule

`default_nettype wire

// File: rtl/rtlr_ctrl.sv
// controller: sequences capture, interval division, state update and result push
// depends on rtlr_pkg
`default_nettype none

module rtlr_ctrl
  import rtlr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.start_ok) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_PUSH;
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a division only starts together with an accepted beat
  a_div_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> (in_valid_i && !in_stall_o && cmd_o.capture))
    else $error("divider started without an accepted beat");

  // a finished division leads straight to the update
  a_div_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_APPLY))
    else $error("finished division not followed by update");

  // the update is always followed by a push attempt and no new beat meanwhile
  a_apply_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> (state_q == S_PUSH && in_stall_o))
    else $error("update not followed by push");

endmodule

`default_nettype wire

// File: rtl/rgb_timed_level_ramp.sv
// rgb timed level ramp: three colour levels driven by timed linear ramps
// depends on rtlr_pkg, rtlr_ctrl and rtlr_dp
//
// usage
//   input channel (in_valid_i / in_stall_o / in_data_i): one beat per item; a tick
//   beat stands for one millisecond, a start beat loads a ramp on one channel,
//   a set beat writes a level, a clear beat zeroes all levels.
//   output channel (out_valid_o / out_stall_i / out_data_o): one beat per item with
//   all three levels and a done flag per colour, taken after the item's update.
//   sequencing: tick, set and clear items pass from accept through the update to the
//   output register; a start item first waits for the serial divider that computes
//   the step interval, and the next item is taken once the current result is pushed.
//   one item is in work at a time; the output register holds one finished beat, so
//   the next item is taken while the last result waits.
//   a stalled receiver holds the result; a new result then waits in the controller
//   and the input stays stalled until the output register frees.
//   reset: all levels, targets and counters clear, step sizes read 1, no output beat
//   is pending; no clearing pass is needed.
`default_nettype none

module rgb_timed_level_ramp
  import rtlr_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  rtlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ramp state and result register
  rtlr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/rgb_timed_level_ramp_test.sv
// self-checking test of rgb_timed_level_ramp: directed and random item streams,
// each result beat checked against a cycle-free ramp predictor kept in this file
// depends on rtlr_pkg (in_t, out_t, kind_e) and the rgb_timed_level_ramp rtl
module rgb_timed_level_ramp_test;
  import rtlr_pkg::*;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int unsigned NCH = 3;
  localparam int unsigned IDLE_TICKS = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // shared between the stimulus tasks, the result sink and the beat checker
  int unsigned errors = 0;
  bit no_gaps = 1'b0;
  int unsigned long_hold = 0;
  out_t levels_due[$];

  // predicted per-channel ramp state
  logic [7:0] lvl [NCH] = '{default: '0};
  logic [7:0] origin_lvl [NCH] = '{default: '0};
  logic [7:0] goal_lvl [NCH] = '{default: '0};
  logic [7:0] step_by [NCH] = '{default: 8'd1};
  logic [14:0] step_gap [NCH] = '{default: '0};
  logic [15:0] idle_ms [NCH] = '{default: '0};
  logic jump [NCH] = '{default: 1'b0};

  rgb_timed_level_ramp u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one ramp evaluation of channel c
  function automatic void step_channel(int unsigned c);
    int cur;
    int amt;
    int nxt;
    if (jump[c]) begin
      lvl[c] = goal_lvl[c];
    end else if (lvl[c] != goal_lvl[c] && idle_ms[c] >= {1'b0, step_gap[c]}) begin
      idle_ms[c] = '0;
      cur = int'(lvl[c]);
      amt = int'(step_by[c]);
      if (goal_lvl[c] >= origin_lvl[c]) begin
        nxt = (cur + amt > int'(goal_lvl[c])) ? int'(goal_lvl[c]) : cur + amt;
      end else if (amt >= cur || cur - amt < int'(goal_lvl[c])) begin
        nxt = int'(goal_lvl[c]);
      end else begin
        nxt = cur - amt;
      end
      lvl[c] = 8'(nxt);
    end
  endfunction

  // apply one accepted item to the predicted state, return the levels it reports
  function automatic out_t advance_levels(in_t it);
    int unsigned c;
    int unsigned delta;
    out_t res;
    case (it.kind)
      KIND_TICK: begin
        for (c = 0; c < NCH; c++) begin
          if (idle_ms[c] != 16'hFFFF) idle_ms[c] = idle_ms[c] + 16'd1;
          step_channel(c);
        end
      end
      KIND_START: begin
        if (it.channel < NCH) begin
          c = it.channel;
          origin_lvl[c] = lvl[c];
          goal_lvl[c] = it.target;
          step_by[c] = it.step_size;
          delta = (it.target >= lvl[c]) ? int'(it.target) - int'(lvl[c])
                                         : int'(lvl[c]) - int'(it.target);
          step_gap[c] = (delta == 0) ? '0 : 15'(int'(it.fade_ms) / delta);
          jump[c] = (it.fade_ms == '0);
          step_channel(c);
        end
      end
      KIND_SET: begin
        if (it.channel < NCH) begin
          c = it.channel;
          lvl[c] = it.target;
          origin_lvl[c] = it.target;
          goal_lvl[c] = it.target;
          jump[c] = 1'b0;
        end
      end
      default: begin
        for (c = 0; c < NCH; c++) begin
          lvl[c] = '0;
          origin_lvl[c] = '0;
          goal_lvl[c] = '0;
          jump[c] = 1'b0;
        end
      end
    endcase
    res.red_level = lvl[0];
    res.green_level = lvl[1];
    res.blue_level = lvl[2];
    res.red_done = (lvl[0] == goal_lvl[0]);
    res.green_done = (lvl[1] == goal_lvl[1]);
    res.blue_done = (lvl[2] == goal_lvl[2]);
    return res;
  endfunction

  function automatic in_t make_item(kind_e k, int unsigned ch, int unsigned tgt,
                                    int unsigned stp, int unsigned rt);
    in_t it;
    it.kind = k;
    it.channel = 2'(ch);
    it.target = 8'(tgt);
    it.step_size = 8'(stp);
    it.fade_ms = 15'(rt);
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.kind = kind_e'($urandom_range(0, 3));
    it.channel = 2'($urandom_range(0, 3));
    it.target = 8'($urandom_range(0, 255));
    it.step_size = 8'($urandom_range(0, 255));
    it.fade_ms = 15'($urandom_range(0, 32767));
    return it;
  endfunction

  // drive one beat, called and returning at a falling edge
  task automatic send_item(input in_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    levels_due.push_back(advance_levels(it));
    @(negedge clk);
  endtask

  // sender pause until every expected beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (levels_due.size() != 0) @(negedge clk);
  endtask

  // result sink: random stall before each beat, or a long hold when asked
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_hold != 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // compare each accepted beat with the oldest prediction
  always @(posedge clk) begin : check_beat
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errors++;
      end else begin
        want = levels_due.pop_front();
        if (out_data.red_level !== want.red_level) begin
          $error("red_level: expected %0d, got %0d", want.red_level, out_data.red_level);
          errors++;
        end
        if (out_data.green_level !== want.green_level) begin
          $error("green_level: expected %0d, got %0d", want.green_level,
                 out_data.green_level);
          errors++;
        end
        if (out_data.blue_level !== want.blue_level) begin
          $error("blue_level: expected %0d, got %0d", want.blue_level, out_data.blue_level);
          errors++;
        end
        if (out_data.red_done !== want.red_done) begin
          $error("red_done: expected %0d, got %0d", want.red_done, out_data.red_done);
          errors++;
        end
        if (out_data.green_done !== want.green_done) begin
          $error("green_done: expected %0d, got %0d", want.green_done, out_data.green_done);
          errors++;
        end
        if (out_data.blue_done !== want.blue_done) begin
          $error("blue_done: expected %0d, got %0d", want.blue_done, out_data.blue_done);
          errors++;
        end
      end
    end
  end

  // levels right after reset
  task automatic test_reset_values();
    send_item(make_item(KIND_TICK, 0, 0, 0, 0));
  endtask

  // direct writes, a write to the missing channel, and clear all
  task automatic test_set_and_clear();
    send_item(make_item(KIND_SET, 0, 255, 0, 0));
    send_item(make_item(KIND_SET, 1, 8'h5a, 0, 0));
    send_item(make_item(KIND_SET, 2, 8'ha5, 255, 32767));
    send_item(make_item(KIND_SET, 3, 8'h33, 0, 0));
    send_item(make_item(KIND_TICK, 3, 255, 255, 32767));
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0));
  endtask

  // ramp time 0 jumps straight to the target
  task automatic test_jump_to_target();
    send_item(make_item(KIND_START, 0, 255, 1, 0));
    send_item(make_item(KIND_START, 1, 128, 255, 0));
    send_item(make_item(KIND_START, 2, 0, 7, 0));
    send_item(make_item(KIND_START, 3, 99, 1, 0));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0));
  endtask

  // timed ramps up and down, clamping at the target and at zero, zero step size
  task automatic test_timed_ramps();
    send_item(make_item(KIND_START, 0, 0, 255, 32767));
    send_item(make_item(KIND_START, 1, 200, 0, 50));
    send_item(make_item(KIND_START, 2, 10, 3, 5));
    repeat (5) send_item(make_item(KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(KIND_SET, 2, 20, 0, 0));
    send_item(make_item(KIND_START, 2, 18, 5, 2));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(KIND_SET, 1, 5, 0, 0));
    send_item(make_item(KIND_START, 1, 0, 255, 1));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0));
  endtask

  // a long idle run lets a fresh start take its first step at once
  task automatic test_long_idle();
    in_t it;
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0));
    no_gaps = 1'b1;
    repeat (IDLE_TICKS) begin
      it = random_item();
      it.kind = KIND_TICK;
      send_item(it);
    end
    no_gaps = 1'b0;
    send_item(make_item(KIND_START, 0, 1, 1, 60));
    send_item(make_item(KIND_START, 1, 1, 1, 32767));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0));
  endtask

  // mixed items with no idling on either side
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (40) send_item(random_item());
    no_gaps = 1'b0;
  endtask

  // long receiver hold so the block backs up, then a sender pause
  task automatic test_output_hold();
    long_hold = 300;
    repeat (12) send_item(random_item());
    wait_drained();
    repeat (10) send_item(random_item());
  endtask

  // ramps with random content followed by runs of ticks, plus stray items
  task automatic test_random_ramps();
    in_t it;
    int unsigned n;
    repeat (30) begin
      it = random_item();
      it.kind = KIND_START;
      it.channel = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) begin
        it.step_size = '0;
      end else if ($urandom_range(0, 1) == 0) begin
        it.step_size = 8'($urandom_range(1, 16));
      end
      if ($urandom_range(0, 3) != 0) it.fade_ms = 15'($urandom_range(0, 400));
      send_item(it);
      n = $urandom_range(1, 30);
      repeat (n) begin
        it = random_item();
        it.kind = KIND_TICK;
        send_item(it);
      end
      if ($urandom_range(0, 2) == 0) send_item(random_item());
    end
  endtask

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL rgb_timed_level_ramp");
    $finish;
  end

  // test sequence
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_set_and_clear();
    test_jump_to_target();
    test_timed_ramps();
    test_long_idle();
    test_back_to_back();
    test_output_hold();
    test_random_ramps();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS rgb_timed_level_ramp");
    end else begin
      $display("FAIL rgb_timed_level_ramp");
    end
    $finish;
  end

endmodule
